FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/are_pkg.sv
// ----------------------------------------------------------------------------
// are_pkg
// Shared types and constants of the axis reduction engine.
// ----------------------------------------------------------------------------
`default_nettype none
package are_pkg;
  localparam logic [2:0] MODE_SUM  = 3'd0;
  localparam logic [2:0] MODE_MEAN = 3'd1;
  localparam logic [2:0] MODE_MIN  = 3'd2;
  localparam logic [2:0] MODE_MAX  = 3'd3;
  localparam logic [2:0] MODE_PROD = 3'd4;
  localparam logic [2:0] MODE_ANY  = 3'd5;
  localparam logic [2:0] MODE_ALL  = 3'd6;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_INNER = 2'd1;
  localparam logic [1:0] REG_AXIS  = 2'd2;
  localparam logic [1:0] REG_OUTER = 2'd3;

  typedef struct packed {
    logic        seed;
    logic        last;
    logic        blk;
    logic        tend;
  } are_ctrl_t;
endpackage
`default_nettype wire

FILE: rtl/core/are_front.sv
// ----------------------------------------------------------------------------
// are_front
// Accepts elements, tracks the tensor position and classifies each word.
// ----------------------------------------------------------------------------
`default_nettype none
module are_front import are_pkg::*; #(
  parameter int PW = 10,
  parameter int MAX_INNER = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clr,
  input  wire logic [10:0]   inner_size,
  input  wire logic [15:0]   axis_length,
  input  wire logic [15:0]   outer_count,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [31:0]   element,
  output logic               q_valid,
  input  wire logic          q_stall,
  output logic [31:0]        q_data,
  output logic [PW-1:0]      q_pos,
  output are_ctrl_t          q_ctrl
);
  localparam int QD = 2;
  logic [31:0]   qd [QD];
  logic [PW-1:0] qp [QD];
  are_ctrl_t     qc [QD];
  logic          wp, rp;
  logic [1:0]    cnt;
  logic [16:0]   ip;
  logic [15:0]   ap, op;
  logic [16:0]   n_in;
  logic [15:0]   n_ax, n_out;
  logic          acc, deq;

  always_comb begin
    n_in = {6'd0, inner_size};
    if (inner_size == 11'd0) n_in = 17'd1;
    else if ({6'd0, inner_size} > 17'(MAX_INNER)) n_in = 17'(MAX_INNER);
    n_ax = (axis_length == 16'd0) ? 16'd1 : axis_length;
    n_out = (outer_count == 16'd0) ? 16'd1 : outer_count;
  end

  assign in_stall = (cnt == 2'(QD));
  assign acc = in_valid && !in_stall;
  assign q_valid = (cnt != 2'd0);
  assign deq = q_valid && !q_stall;
  assign q_data = qd[rp];
  assign q_pos = qp[rp];
  assign q_ctrl = qc[rp];

  always_ff @(posedge clk) begin
    if (acc) begin
      qd[wp] <= element;
      qp[wp] <= ip[PW-1:0];
      qc[wp].seed <= (ap == 16'd0);
      qc[wp].last <= (ap == n_ax - 16'd1);
      qc[wp].blk <= (ip == n_in - 17'd1);
      qc[wp].tend <= (ip == n_in - 17'd1) && (op == n_out - 16'd1);
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (acc) wp <= ~wp;
      if (deq) rp <= ~rp;
      cnt <= cnt + 2'(acc) - 2'(deq);
    end
    if (rst || clr) begin
      ip <= 17'd0;
      ap <= 16'd0;
      op <= 16'd0;
    end else if (acc) begin
      if (ip >= n_in - 17'd1) begin
        ip <= 17'd0;
        if (ap >= n_ax - 16'd1) begin
          ap <= 16'd0;
          op <= (op >= n_out - 16'd1) ? 16'd0 : op + 16'd1;
        end else begin
          ap <= ap + 16'd1;
        end
      end else begin
        ip <= ip + 17'd1;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/are_div.sv
// ----------------------------------------------------------------------------
// are_div
// Restoring divider of a signed dividend by an unsigned divisor, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
`default_nettype none
module are_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [31:0] q;
  logic [32:0] r;
  logic [15:0] d;
  logic [5:0]  n;
  logic        neg;
  logic [32:0] t;

  assign t = {r[31:0], q[31]} - {17'd0, d};
  assign quotient = neg ? 32'(-q) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        n <= 6'd0;
        neg <= dividend[31];
        q <= dividend[31] ? 32'(-dividend) : dividend;
        r <= 33'd0;
        d <= divisor;
      end else if (busy) begin
        if (t[32]) begin
          r <= {r[31:0], q[31]};
          q <= {q[30:0], 1'b0};
        end else begin
          r <= t;
          q <= {q[30:0], 1'b1};
        end
        n <= n + 6'd1;
        if (n == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/are_back.sv
// ----------------------------------------------------------------------------
// are_back
// Reads and updates the accumulator memory and delivers the results.
// ----------------------------------------------------------------------------
`default_nettype none
module are_back import are_pkg::*; #(
  parameter int PW = 10,
  parameter int MAX_INNER = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [2:0]  reduce_mode,
  input  wire logic [15:0] axis_length,
  input  wire logic        q_valid,
  output logic             q_stall,
  input  wire logic [31:0] q_data,
  input  wire logic [PW-1:0] q_pos,
  input  are_ctrl_t        q_ctrl,
  output logic             valid,
  input  wire logic        stall,
  output logic [31:0]      reduced,
  output logic             block_end,
  output logic             tensor_end
);
  localparam logic [1:0] S_READ = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [31:0] mem [MAX_INNER];
  logic [31:0] rd, x, res, prod;
  logic [PW-1:0] pos;
  are_ctrl_t   ctl;
  logic [1:0]  state;
  logic [15:0] n_ax;
  logic        dstart, dbusy, ddone;
  logic [31:0] quo;

  assign n_ax = (axis_length == 16'd0) ? 16'd1 : axis_length;
  assign q_stall = (state != S_READ) || dbusy;
  assign prod = 32'(rd * x);

  // The divider latches its dividend from res and its divisor from n_ax while dstart is high.
  are_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(res), .divisor(n_ax),
    .busy(dbusy), .done(ddone), .quotient(quo)
  );

  always_comb begin
    if (ctl.seed) begin
      case (reduce_mode)
        MODE_ANY: res = {31'd0, !x[31] && (x != 32'd0)};
        MODE_ALL: res = {31'd0, x != 32'd0};
        default:  res = x;
      endcase
    end else begin
      case (reduce_mode)
        MODE_MIN:  res = ($signed(x) < $signed(rd)) ? x : rd;
        MODE_MAX:  res = ($signed(x) > $signed(rd)) ? x : rd;
        MODE_PROD: res = prod;
        MODE_ANY:  res = {31'd0, (rd != 32'd0) || (!x[31] && (x != 32'd0))};
        MODE_ALL:  res = {31'd0, (rd != 32'd0) && (x != 32'd0)};
        default:   res = rd + x;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && !q_stall) begin
      rd <= mem[q_pos];
      x <= q_data;
      pos <= q_pos;
      ctl <= q_ctrl;
    end
    if (state == S_CALC) begin
      mem[pos] <= res;
      reduced <= res;
      block_end <= ctl.blk;
      tensor_end <= ctl.tend;
    end
    if (ddone) reduced <= quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_READ;
      valid <= 1'b0;
      dstart <= 1'b0;
    end else begin
      dstart <= 1'b0;
      unique case (state)
        S_READ: if (q_valid && !q_stall) state <= S_CALC;
        S_CALC: begin
          if (!ctl.last) state <= S_READ;
          else if (reduce_mode == MODE_MEAN) begin
            dstart <= 1'b1;
            state <= S_DIV;
          end else begin
            valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_DIV: if (ddone) begin
          valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (!stall) begin
          valid <= 1'b0;
          state <= S_READ;
        end
        default: state <= S_READ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/axis_reduction_engine_core.sv
// ----------------------------------------------------------------------------
// axis_reduction_engine_core
// Reduces a stream of signed 32-bit tensor elements along the middle axis.
// ----------------------------------------------------------------------------
// The back end reads the accumulator and then updates it for each element;
// when a result is due it then delivers it, in mean mode after a divide
// state on the bit-serial divider, and a stall on the output holds it there.
// It takes no new element until it is back in its read state. A two-word
// queue decouples the input from the back end. Results are held until taken.
`default_nettype none
module axis_reduction_engine_core import are_pkg::*; #(
  parameter int MAX_INNER = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] element,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      reduced,
  output logic             block_end,
  output logic             tensor_end
);
  localparam int PW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  logic [2:0]  reduce_mode;
  logic [10:0] inner_size;
  logic [15:0] axis_length, outer_count;
  logic        wr;
  logic        q_valid, q_stall;
  logic [31:0] q_data;
  logic [PW-1:0] q_pos;
  are_ctrl_t   q_ctrl;

  assign cfg_ready = 1'b1;
  assign wr = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_mode <= MODE_SUM;
      inner_size <= 11'd1;
      axis_length <= 16'd1;
      outer_count <= 16'd1;
    end else if (wr) begin
      unique case (cfg_index)
        REG_MODE:  reduce_mode <= cfg_data[2:0];
        REG_INNER: inner_size <= cfg_data[10:0];
        REG_AXIS:  axis_length <= cfg_data[15:0];
        REG_OUTER: outer_count <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  are_front #(.PW(PW), .MAX_INNER(MAX_INNER)) u_front (
    .clk(clk), .rst(rst), .clr(wr), .inner_size(inner_size),
    .axis_length(axis_length), .outer_count(outer_count),
    .in_valid(in_valid), .in_stall(in_stall), .element(element),
    .q_valid(q_valid), .q_stall(q_stall), .q_data(q_data),
    .q_pos(q_pos), .q_ctrl(q_ctrl)
  );

  are_back #(.PW(PW), .MAX_INNER(MAX_INNER)) u_back (
    .clk(clk), .rst(rst), .reduce_mode(reduce_mode), .axis_length(axis_length),
    .q_valid(q_valid), .q_stall(q_stall), .q_data(q_data), .q_pos(q_pos),
    .q_ctrl(q_ctrl), .valid(out_valid), .stall(out_stall), .reduced(reduced),
    .block_end(block_end), .tensor_end(tensor_end)
  );
endmodule
`default_nettype wire

FILE: rtl/core/are_checker.sv
// ----------------------------------------------------------------------------
// are_checker
// Port-level checks on the reduction engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module are_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] reduced,
  input wire logic        block_end,
  input wire logic        tensor_end
);
  `ASSERT_IMPL(a_tend_blk, clk, rst, out_valid && tensor_end, block_end)
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(reduced))
  `ASSERT_NEXT(a_gap, clk, rst, out_valid && !out_stall, !out_valid)
endmodule

bind axis_reduction_engine_core are_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .reduced(reduced), .block_end(block_end), .tensor_end(tensor_end)
);
`default_nettype wire
